// ===== hdl/rtlpm_pkg.sv =====
// ----------------------------------------------------------------------------
// rtlpm_pkg
// shared types and constants of the ipv4 route table engine
// ----------------------------------------------------------------------------
package rtlpm_pkg;

    localparam int TableDepth = 16;
    localparam int IdxW       = $clog2(TableDepth);
    localparam int CntW       = $clog2(TableDepth + 1);

    // entry layout: port_present, port, flags, ifaddr, gateway, mask, dest
    localparam int EntryW = 1 + 4 + 8 + 32 * 4;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REJECT   = 2'd1,
        ST_NO_ROUTE = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    localparam logic [7:0] FlagUp    = 8'h01;
    localparam logic [7:0] FlagGw    = 8'h02;
    localparam logic [7:0] FlagLocal = 8'h04;
    localparam logic [7:0] FlagConn  = 8'h08;

    // preference codes, ordered like 300 / 200 / 100 / 0
    localparam logic [1:0] PrefLocal = 2'd3;
    localparam logic [1:0] PrefConn  = 2'd2;
    localparam logic [1:0] PrefOther = 2'd1;
    localparam logic [1:0] PrefDflt  = 2'd0;

    typedef struct packed {
        logic        port_present;
        logic [3:0]  port;
        logic [7:0]  flags;
        logic [31:0] ifaddr;
        logic [31:0] gateway;
        logic [31:0] mask;
        logic [31:0] dest;
    } t_entry;

    function automatic logic [1:0] pref_of(input logic [7:0] flags, input logic [31:0] mask);
        logic [1:0] p;
        if ((flags & FlagLocal) != 8'd0)     p = PrefLocal;
        else if ((flags & FlagConn) != 8'd0) p = PrefConn;
        else if (mask == 32'd0)              p = PrefDflt;
        else                                 p = PrefOther;
        return p;
    endfunction

endpackage

// ===== hdl/ipv4_route_table_lpm.sv =====
// ----------------------------------------------------------------------------
// ipv4_route_table_lpm
// ordered ipv4 route table with add, delete, longest prefix lookup and read
// ----------------------------------------------------------------------------
// flow: a rejected add goes straight to the result, a read fetches the one
//   entry, add or lookup scan the entries (an add stops at a matching entry)
// delete scans, then shifts later entries down one per cycle
// throughput: one transaction at a time, a new one is taken only after the
//   result has been accepted
// reset: entry count cleared, table contents left undefined
module ipv4_route_table_lpm
    import rtlpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_route_dest,
    input  logic [31:0] i_route_mask,
    input  logic [31:0] i_route_gateway,
    input  logic [31:0] i_route_ifaddr,
    input  logic [7:0]  i_route_flags,
    input  logic [3:0]  i_port_index,
    input  logic        i_port_present,
    input  logic [31:0] i_lookup_address,
    input  logic [3:0]  i_entry_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_hit_dest,
    output logic [31:0] o_hit_mask,
    output logic [31:0] o_hit_gateway,
    output logic [31:0] o_hit_ifaddr,
    output logic [7:0]  o_hit_flags,
    output logic [3:0]  o_hit_port,
    output logic        o_hit_port_present,
    output logic [31:0] o_next_hop,
    output logic [3:0]  o_hit_position,
    output logic [4:0]  o_entry_count
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_SHIFT = 6'b000100,
        S_FETCH = 6'b001000,
        S_DONE  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // captured transaction
    t_cmd        r_cmd;
    t_entry      r_req;
    logic [31:0] r_addr;
    logic [IdxW-1:0] r_idx;

    logic [CntW-1:0] r_count, n_count;
    logic [CntW-1:0] r_ptr, n_ptr;      // address issued to the ram
    logic            r_rd_vld, n_rd_vld; // ram data valid this cycle
    logic [IdxW-1:0] r_rd_pos, n_rd_pos;

    // best match tracking
    logic            r_have, n_have;
    t_entry          r_best, n_best;
    logic [IdxW-1:0] r_best_pos, n_best_pos;
    logic [1:0]      r_best_pref, n_best_pref;

    // ram ports
    logic            ram_we;
    logic [IdxW-1:0] ram_waddr, ram_raddr;
    t_entry          ram_wdata, ram_rdata;

    // result register
    logic        r_ovalid;
    t_status     r_status, n_status;
    t_entry      r_hit, n_hit;
    logic [31:0] r_next_hop, n_next_hop;
    logic [IdxW-1:0] r_hit_pos, n_hit_pos;

    logic [CntW-1:0] r_count_ok;

    rtlpm_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    logic       in_fire;
    logic       match_add, match_del, match_lkp, better;
    logic [1:0] cur_pref;

    assign in_fire = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign ram_raddr = r_ptr[IdxW-1:0];

    // compare of the entry just read
    always_comb begin
        match_add = (ram_rdata.dest == r_req.dest) && (ram_rdata.mask == r_req.mask) &&
                    ram_rdata.port_present && r_req.port_present &&
                    (ram_rdata.port == r_req.port);
        match_del = (ram_rdata.dest == r_req.dest) && (ram_rdata.mask == r_req.mask);
        match_lkp = ((ram_rdata.flags & FlagUp) != 8'd0) &&
                    ((r_addr & ram_rdata.mask) == (ram_rdata.dest & ram_rdata.mask));
        cur_pref  = pref_of(ram_rdata.flags, ram_rdata.mask);
        better    = !r_have || (ram_rdata.mask > r_best.mask) ||
                    ((ram_rdata.mask == r_best.mask) && (cur_pref > r_best_pref));
    end

    // command sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_rd_vld    = 1'b0;
        n_rd_pos    = r_ptr[IdxW-1:0];
        n_have      = r_have;
        n_best      = r_best;
        n_best_pos  = r_best_pos;
        n_best_pref = r_best_pref;
        n_status    = r_status;
        n_hit       = r_hit;
        n_next_hop  = r_next_hop;
        n_hit_pos   = r_hit_pos;
        ram_we      = 1'b0;
        ram_waddr   = r_rd_pos;
        ram_wdata   = r_req;
        unique case (r_state)
            S_IDLE: begin
                n_ptr  = '0;
                n_have = 1'b0;
                if (in_fire) begin
                    n_hit      = '0;
                    n_next_hop = '0;
                    n_hit_pos  = '0;
                    n_status   = ST_OK;
                    if (t_cmd'(i_cmd) == CMD_READ) begin
                        n_ptr   = CntW'(i_entry_index);
                        n_state = S_FETCH;
                    end else if (t_cmd'(i_cmd) == CMD_ADD &&
                                 i_route_dest == 32'd0 && i_route_mask != 32'd0) begin
                        n_status = ST_REJECT;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // issue next address while the previous read returns
                if (r_ptr < r_count) begin
                    n_ptr    = r_ptr + 1'b1;
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld) begin
                    unique case (r_cmd)
                        CMD_ADD: if (match_add) begin
                            ram_we     = 1'b1;
                            ram_wdata  = ram_rdata;
                            ram_wdata.gateway = r_req.gateway;
                            ram_wdata.ifaddr  = r_req.ifaddr;
                            ram_wdata.flags   = r_req.flags;
                            n_hit     = ram_wdata;
                            n_hit_pos = r_rd_pos;
                            n_state   = S_DONE;
                        end
                        CMD_DELETE: if (match_del) begin
                            n_hit     = ram_rdata;
                            n_hit_pos = r_rd_pos;
                            // restart reads at the next entry for the shift
                            n_ptr     = CntW'(r_rd_pos) + 1'b1;
                            n_rd_vld  = 1'b0;
                            n_state   = S_SHIFT;
                        end
                        default: if (match_lkp && better) begin
                            n_have      = 1'b1;
                            n_best      = ram_rdata;
                            n_best_pos  = r_rd_pos;
                            n_best_pref = cur_pref;
                        end
                    endcase
                end
                // scan finished with no early exit
                if (n_state == S_SCAN && !n_rd_vld && !(r_ptr < r_count)) begin
                    unique case (r_cmd)
                        CMD_ADD: begin
                            if (r_count >= CntW'(TableDepth)) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[IdxW-1:0];
                                ram_wdata = r_req;
                                n_hit     = r_req;
                                n_hit_pos = r_count[IdxW-1:0];
                                n_count   = r_count + 1'b1;
                            end
                        end
                        CMD_DELETE: n_status = ST_REJECT;
                        default: begin
                            if (!n_have) begin
                                n_status = ST_NO_ROUTE;
                            end else begin
                                n_hit      = n_best;
                                n_hit_pos  = n_best_pos;
                                n_next_hop = ((n_best.flags & FlagGw) != 8'd0) ?
                                             n_best.gateway : r_addr;
                            end
                        end
                    endcase
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                // read entry i+1, write it at i
                if (r_rd_vld) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_rd_pos - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (r_ptr < r_count) begin
                    n_ptr    = r_ptr + 1'b1;
                    n_rd_vld = 1'b1;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = S_DONE;
                end
            end
            S_FETCH: begin
                if (!r_rd_vld) begin
                    n_rd_vld = 1'b1;
                    if (r_ptr >= r_count) begin
                        n_status = ST_NO_ROUTE;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_hit     = ram_rdata;
                    n_hit_pos = r_rd_pos;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_vld <= n_rd_vld;
            if (r_state == S_DONE) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_rd_pos    <= n_rd_pos;
        r_have      <= n_have;
        r_best      <= n_best;
        r_best_pos  <= n_best_pos;
        r_best_pref <= n_best_pref;
        r_status    <= n_status;
        r_hit       <= n_hit;
        r_next_hop  <= n_next_hop;
        r_hit_pos   <= n_hit_pos;
        if (r_state == S_DONE) begin
            r_count_ok <= r_count;
        end
        if (in_fire) begin
            r_cmd              <= t_cmd'(i_cmd);
            r_req.dest         <= i_route_dest;
            r_req.mask         <= i_route_mask;
            r_req.gateway      <= i_route_gateway;
            r_req.ifaddr       <= i_route_ifaddr;
            r_req.flags        <= i_route_flags | FlagUp;
            r_req.port         <= i_port_index;
            r_req.port_present <= i_port_present;
            r_addr             <= i_lookup_address;
            r_idx              <= i_entry_index;
        end
    end

    // result port
    assign o_valid            = r_ovalid;
    assign o_status           = r_status;
    assign o_hit_dest         = r_hit.dest;
    assign o_hit_mask         = r_hit.mask;
    assign o_hit_gateway      = r_hit.gateway;
    assign o_hit_ifaddr       = r_hit.ifaddr;
    assign o_hit_flags        = r_hit.flags;
    assign o_hit_port         = r_hit.port;
    assign o_hit_port_present = r_hit.port_present;
    assign o_next_hop         = (r_cmd == CMD_LOOKUP) ? r_next_hop : 32'd0;
    assign o_hit_position     = (r_cmd == CMD_READ && r_status == ST_OK) ? r_idx : r_hit_pos;
    assign o_entry_count      = r_count_ok;
endmodule

// ===== hdl/rtlpm_ram.sv =====
// ----------------------------------------------------------------------------
// rtlpm_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module rtlpm_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/rtlpm_checker.sv =====
// ----------------------------------------------------------------------------
// rtlpm_checker
// port level checks of the route table engine
// ----------------------------------------------------------------------------
module rtlpm_checker
    import rtlpm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [31:0] o_hit_dest,
    input logic [31:0] o_next_hop,
    input logic [4:0]  o_entry_count
);
    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result dropped while stalled");

    // no input taken while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(i_valid && o_ready))
        else $error("input accepted with result pending");

    // count never exceeds depth
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entry_count <= 5'(TableDepth))
        else $error("entry count out of range");

    // failed status carries empty fields
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != 2'd0 |-> o_hit_dest == 32'd0 && o_next_hop == 32'd0)
        else $error("nonzero payload on failure");
endmodule

bind ipv4_route_table_lpm rtlpm_checker u_rtlpm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_hit_dest    (o_hit_dest),
    .o_next_hop    (o_next_hop),
    .o_entry_count (o_entry_count)
);
